@@ hw/rtl/assert_macros.svh @@
// assertion macros of the receiver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FPR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define FPR_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  `FPR_ASSERT(lbl, clk, rstn, (ante) |-> (cons))
`define FPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `FPR_ASSERT(lbl, clk, rstn, (ante) |=> (cons))
`else
`define FPR_ASSERT(lbl, clk, rstn, prop)
`define FPR_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define FPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hw/rtl/fpr_pkg.sv @@
// types and constants of the framed packet receiver
package fpr_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ACK     = 2'd2,
    KIND_ERROR   = 2'd3
  } fpr_kind_t;

  typedef enum logic [3:0] {
    S_WAIT,
    S_HEADER,
    S_SIZE,
    S_DATA,
    S_CHECK,
    S_RD,
    S_PL,
    S_EMPTY,
    S_ACK,
    S_ERR
  } fpr_state_t;

  typedef enum logic [1:0] {
    VSEL_ZERO,
    VSEL_RAM,
    VSEL_ACK
  } fpr_vsel_t;

  typedef enum logic [2:0] {
    ACK_MARK0,
    ACK_MARK1,
    ACK_HDR0,
    ACK_NULL,
    ACK_HDR1
  } fpr_ack_t;

  typedef enum logic {
    REG_START_MARKER  = 1'b0,
    REG_SETPOINT_PORT = 1'b1
  } fpr_reg_t;

  localparam logic [7:0] START_MARKER_RST  = 8'hAA;
  localparam logic [3:0] SETPOINT_PORT_RST = 4'h3;
  localparam logic [7:0] ACK_NULL_BYTE     = 8'h00;

  typedef struct packed {
    logic      hdr_load;
    logic      size_load;
    logic      data_wr;
    logic      emit_clr;
    logic      rd_en;
    logic      drain_inc;
    logic      ack_inc;
    logic      out_load;
    fpr_kind_t out_kind;
    fpr_vsel_t out_vsel;
    logic      out_last;
  } fpr_cmd_t;

  typedef struct packed {
    logic is_marker;
    logic size_over;
    logic size_zero;
    logic size_r_zero;
    logic fill_done;
    logic sum_match;
    logic drain_done;
    logic ack_done;
    logic out_free;
  } fpr_status_t;

endpackage

@@ hw/rtl/fpr_ram.sv @@
// generic single-port-write, registered-read ram
module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 30
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/fpr_dpath.sv @@
// receiver datapath: frame registers, checksum, payload store, output register
module fpr_dpath #(
  parameter int MAX_PAYLOAD = 30
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fpr_pkg::fpr_cmd_t   cmd,
  output fpr_pkg::fpr_status_t st,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          start_marker,
  input  logic [3:0]          setpoint_port,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [1:0]          out_kind,
  output logic [3:0]          out_port,
  output logic [1:0]          out_channel,
  output logic                out_to_setpoint,
  output logic [4:0]          out_length,
  output logic [4:0]          out_position,
  output logic [7:0]          out_value,
  output logic                out_last
);
  import fpr_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]    header_r, header_nxt;
  logic [7:0]    size_r, size_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] drain_r, drain_nxt;
  logic [2:0]    ack_r, ack_nxt;
  logic          valid_r, valid_nxt;
  logic [7:0]    ram_rdata;
  logic [7:0]    value_sel;
  logic [7:0]    drain_pos;

  fpr_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_store (
    .clk  (clk),
    .we   (cmd.data_wr),
    .waddr(fill_r[AW-1:0]),
    .wdata(rx_byte),
    .re   (cmd.rd_en),
    .raddr(drain_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    header_nxt = header_r;
    size_nxt   = size_r;
    sum_nxt    = sum_r;
    fill_nxt   = fill_r;
    drain_nxt  = drain_r;
    ack_nxt    = ack_r;
    if (cmd.hdr_load) begin
      header_nxt = rx_byte;
      sum_nxt    = rx_byte;
    end
    if (cmd.size_load) begin
      size_nxt = rx_byte;
      sum_nxt  = sum_r + rx_byte;
      fill_nxt = '0;
    end
    if (cmd.data_wr) begin
      sum_nxt  = sum_r + rx_byte;
      fill_nxt = fill_r + 1'b1;
    end
    if (cmd.emit_clr) begin
      drain_nxt = '0;
      ack_nxt   = '0;
    end
    if (cmd.drain_inc) begin
      drain_nxt = drain_r + 1'b1;
    end
    if (cmd.ack_inc) begin
      ack_nxt = ack_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= '0;
      size_r   <= '0;
      sum_r    <= '0;
      fill_r   <= '0;
      drain_r  <= '0;
      ack_r    <= '0;
    end else begin
      header_r <= header_nxt;
      size_r   <= size_nxt;
      sum_r    <= sum_nxt;
      fill_r   <= fill_nxt;
      drain_r  <= drain_nxt;
      ack_r    <= ack_nxt;
    end
  end

  always_comb begin
    st.is_marker   = (rx_byte == start_marker);
    st.size_over   = (rx_byte > 8'(MAX_PAYLOAD));
    st.size_zero   = (rx_byte == 8'd0);
    st.size_r_zero = (size_r == 8'd0);
    st.fill_done   = ((9'(fill_r) + 9'd1) >= {1'b0, size_r});
    st.sum_match   = (sum_r == rx_byte);
    st.drain_done  = ((9'(drain_r) + 9'd1) >= {1'b0, size_r});
    st.ack_done    = (fpr_ack_t'(ack_r) == ACK_HDR1);
    st.out_free    = !valid_r || !out_stall;
  end

  always_comb begin
    value_sel = '0;
    case (cmd.out_vsel)
      VSEL_RAM: value_sel = ram_rdata;
      VSEL_ACK: begin
        case (fpr_ack_t'(ack_r))
          ACK_MARK0, ACK_MARK1: value_sel = start_marker;
          ACK_HDR0, ACK_HDR1:   value_sel = header_r;
          ACK_NULL:             value_sel = ACK_NULL_BYTE;
          default:              value_sel = '0;
        endcase
      end
      default: value_sel = '0;
    endcase
  end

  assign drain_pos = 8'(drain_r);

  // output register: takes a new beat when empty or as the current one leaves
  always_comb begin
    valid_nxt = valid_r;
    if (cmd.out_load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind        <= cmd.out_kind;
      out_port        <= header_r[7:4];
      out_channel     <= header_r[1:0];
      out_to_setpoint <= (header_r[7:4] == setpoint_port);
      out_length      <= size_r[4:0];
      out_position    <= (cmd.out_kind == KIND_PAYLOAD) ? drain_pos[4:0] : 5'd0;
      out_value       <= value_sel;
      out_last        <= cmd.out_last;
    end
  end

  assign out_valid = valid_r;

endmodule

@@ hw/rtl/fpr_ctrl.sv @@
// receiver controller: frame parsing and result sequencing
`include "assert_macros.svh"

module fpr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fpr_pkg::fpr_status_t st,
  output fpr_pkg::fpr_cmd_t    cmd
);
  import fpr_pkg::*;

  fpr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_WAIT: begin
        in_stall = 1'b0;
        if (in_valid && st.is_marker) begin
          state_nxt = S_HEADER;
        end
      end
      S_HEADER: begin
        in_stall = 1'b0;
        // repeated markers keep us waiting for the header
        if (in_valid && !st.is_marker) begin
          cmd.hdr_load = 1'b1;
          state_nxt    = S_SIZE;
        end
      end
      S_SIZE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.size_load = 1'b1;
          if (st.size_over) begin
            state_nxt = S_WAIT;
          end else if (st.size_zero) begin
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_DATA;
          end
        end
      end
      S_DATA: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.data_wr = 1'b1;
          if (st.fill_done) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (st.sum_match) begin
            cmd.emit_clr = 1'b1;
            state_nxt    = st.size_r_zero ? S_EMPTY : S_RD;
          end else begin
            state_nxt = S_ERR;
          end
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_PL;
      end
      S_PL: begin
        if (st.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_kind  = KIND_PAYLOAD;
          cmd.out_vsel  = VSEL_RAM;
          cmd.drain_inc = 1'b1;
          state_nxt     = st.drain_done ? S_ACK : S_RD;
        end
      end
      S_EMPTY: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_EMPTY;
          cmd.out_vsel = VSEL_ZERO;
          state_nxt    = S_ACK;
        end
      end
      S_ACK: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_ACK;
          cmd.out_vsel = VSEL_ACK;
          cmd.out_last = st.ack_done;
          cmd.ack_inc  = 1'b1;
          if (st.ack_done) begin
            state_nxt = S_WAIT;
          end
        end
      end
      S_ERR: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_ERROR;
          cmd.out_vsel = VSEL_ZERO;
          cmd.out_last = 1'b1;
          state_nxt    = S_WAIT;
        end
      end
      default: begin
        state_nxt = S_WAIT;
      end
    endcase
  end

  `FPR_ASSERT_IMPLY(a_load_only_when_free, clk, rst_n, cmd.out_load, st.out_free)
  `FPR_ASSERT_IMPLY(a_no_write_while_stalled, clk, rst_n, cmd.data_wr, !in_stall && in_valid)
  `FPR_ASSERT_IMPLY(a_last_closes_frame, clk, rst_n, cmd.out_load && cmd.out_last,
                    cmd.out_kind == KIND_ACK || cmd.out_kind == KIND_ERROR)
  `FPR_ASSERT_NEXT(a_last_returns_to_wait, clk, rst_n, cmd.out_load && cmd.out_last,
                   state_r == S_WAIT)

endmodule

@@ hw/rtl/framed_packet_receiver.sv @@
// top level of the framed packet receiver
// Takes one received byte per input beat (in_valid / in_stall) and deframes
// frames of marker, header, size, payload and an 8-bit additive checksum.
// While a frame is being received a byte is taken every cycle that in_valid
// is high; payload bytes go into a small store (one write port, registered read).
// After the checksum beat the input is stalled while results are sent on the
// out_ channel: each payload byte is read from the store and then loaded into
// the output register; each empty, acknowledge or error beat is loaded into it
// directly. The first result of a good frame with payload passes the store read
// state, the payload state and the output register; that of an empty or bad
// frame passes the empty or error state and the output register. Input is taken
// again as soon as the last result sits in the output register.
// out_stall freezes a valid output register and the sequencer behind it; nothing is lost.
// Reset (rst_n low, synchronous) returns to waiting for a start marker, clears
// the output valid and loads the marker 0xAA and setpoint port 3.
// The store needs no clearing: only entries written in the current frame
// are read. Registers: start marker at address 0, setpoint port at 4.
module framed_packet_receiver #(
  parameter int MAX_PAYLOAD = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_port,
  output logic [1:0]  out_channel,
  output logic        out_to_setpoint,
  output logic [4:0]  out_length,
  output logic [4:0]  out_position,
  output logic [7:0]  out_value,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fpr_pkg::*;

  logic [7:0]  marker_r, marker_nxt;
  logic [3:0]  sp_port_r, sp_port_nxt;
  logic        cfg_wr;
  fpr_reg_t    reg_sel;
  fpr_cmd_t    cmd;
  fpr_status_t st;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = fpr_reg_t'(cfg_paddr[2]);

  always_comb begin
    marker_nxt  = marker_r;
    sp_port_nxt = sp_port_r;
    cfg_prdata  = '0;
    unique case (reg_sel)
      REG_START_MARKER: begin
        cfg_prdata = {24'd0, marker_r};
        if (cfg_wr) begin
          marker_nxt = cfg_pwdata[7:0];
        end
      end
      REG_SETPOINT_PORT: begin
        cfg_prdata = {28'd0, sp_port_r};
        if (cfg_wr) begin
          sp_port_nxt = cfg_pwdata[3:0];
        end
      end
      default: begin
        cfg_prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r  <= START_MARKER_RST;
      sp_port_r <= SETPOINT_PORT_RST;
    end else begin
      marker_r  <= marker_nxt;
      sp_port_r <= sp_port_nxt;
    end
  end

  fpr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .st      (st),
    .cmd     (cmd)
  );

  fpr_dpath #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .rx_byte        (in_rx_byte),
    .start_marker   (marker_r),
    .setpoint_port  (sp_port_r),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_port       (out_port),
    .out_channel    (out_channel),
    .out_to_setpoint(out_to_setpoint),
    .out_length     (out_length),
    .out_position   (out_position),
    .out_value      (out_value),
    .out_last       (out_last)
  );

endmodule

@@ tb/framed_packet_receiver_test.sv @@
// self-checking testbench of the framed packet receiver
module framed_packet_receiver_test;
  import fpr_pkg::*;

  localparam int MAX_PAYLOAD = 30;

  typedef struct {
    fpr_kind_t  kind;
    logic [3:0] port;
    logic [1:0] channel;
    logic       to_setpoint;
    logic [4:0] length;
    logic [4:0] position;
    logic [7:0] value;
    logic       last;
  } rx_result_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic [5:0] n_res;
    fpr_kind_t  kind;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [3:0]  out_port;
  logic [1:0]  out_channel;
  logic        out_to_setpoint;
  logic [4:0]  out_length;
  logic [4:0]  out_position;
  logic [7:0]  out_value;
  logic        out_last;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // deframer copy: registers, frame state, payload store
  logic [7:0]  marker_q;
  logic [3:0]  sp_port_q;
  fpr_state_t  dfr_phase;
  logic [7:0]  hdr_q;
  logic [7:0]  size_q;
  int          fill_q;
  logic [7:0]  sum_q;
  logic [7:0]  pl_store [MAX_PAYLOAD];

  rx_result_t  pending_results [$];
  int          beat_count;
  fpr_kind_t   beat_last_kind;
  int          err_count = 0;
  int          frame_bytes = 0;
  int          sender_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int          hold_left = 0;

  // rows: byte, typed, result count, kind of the final result
  dir_row_t dir_rows [0:22] = '{
    '{8'h00, 1'b1, 6'd0, KIND_PAYLOAD},   // noise while waiting
    '{8'hFF, 1'b1, 6'd0, KIND_PAYLOAD},
    '{8'hAA, 1'b1, 6'd0, KIND_PAYLOAD},
    '{8'hAA, 1'b1, 6'd0, KIND_PAYLOAD},   // repeated marker skipped
    '{8'h31, 1'b1, 6'd0, KIND_PAYLOAD},   // port 3, the setpoint port
    '{8'h00, 1'b1, 6'd0, KIND_PAYLOAD},   // zero size
    '{8'h31, 1'b1, 6'd6, KIND_ACK},       // empty packet and acknowledge
    '{8'hAA, 1'b1, 6'd0, KIND_PAYLOAD},
    '{8'hF3, 1'b1, 6'd0, KIND_PAYLOAD},
    '{8'h02, 1'b1, 6'd0, KIND_PAYLOAD},
    '{8'hFF, 1'b1, 6'd0, KIND_PAYLOAD},
    '{8'h00, 1'b1, 6'd0, KIND_PAYLOAD},
    '{8'hF4, 1'b0, 6'd0, KIND_PAYLOAD},   // good sum, left to the predictor
    '{8'hAA, 1'b1, 6'd0, KIND_PAYLOAD},
    '{8'h00, 1'b1, 6'd0, KIND_PAYLOAD},
    '{8'h1F, 1'b1, 6'd0, KIND_PAYLOAD},   // one above max size, dropped
    '{8'hAA, 1'b1, 6'd0, KIND_PAYLOAD},
    '{8'h12, 1'b1, 6'd0, KIND_PAYLOAD},
    '{8'h00, 1'b1, 6'd0, KIND_PAYLOAD},
    '{8'h55, 1'b1, 6'd1, KIND_ERROR},     // wrong sum
    '{8'hAA, 1'b1, 6'd0, KIND_PAYLOAD},
    '{8'hC2, 1'b1, 6'd0, KIND_PAYLOAD},
    '{8'hFF, 1'b1, 6'd0, KIND_PAYLOAD}    // largest size, dropped
  };

  framed_packet_receiver u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_port        (out_port),
    .out_channel     (out_channel),
    .out_to_setpoint (out_to_setpoint),
    .out_length      (out_length),
    .out_position    (out_position),
    .out_value       (out_value),
    .out_last        (out_last),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void push_result(fpr_kind_t kind, logic [4:0] pos, logic [7:0] val,
                                      logic is_last);
    rx_result_t r;
    r.kind        = kind;
    r.port        = hdr_q[7:4];
    r.channel     = hdr_q[1:0];
    r.to_setpoint = (hdr_q[7:4] == sp_port_q);
    r.length      = size_q[4:0];
    r.position    = pos;
    r.value       = val;
    r.last        = is_last;
    pending_results.push_back(r);
    beat_count++;
    beat_last_kind = kind;
  endfunction

  // advance the deframer copy by one received byte, queueing what it sends
  function automatic void deframe_byte(logic [7:0] b);
    beat_count = 0;
    beat_last_kind = KIND_PAYLOAD;
    case (dfr_phase)
      S_WAIT: begin
        if (b == marker_q) dfr_phase = S_HEADER;
      end
      S_HEADER: begin
        if (b != marker_q) begin
          hdr_q = b;
          sum_q = b;
          dfr_phase = S_SIZE;
        end
      end
      S_SIZE: begin
        size_q = b;
        sum_q = sum_q + b;
        if (b > MAX_PAYLOAD) dfr_phase = S_WAIT;
        else if (b == 8'd0) dfr_phase = S_CHECK;
        else begin
          fill_q = 0;
          dfr_phase = S_DATA;
        end
      end
      S_DATA: begin
        if (fill_q < MAX_PAYLOAD) pl_store[fill_q] = b;
        fill_q++;
        sum_q = sum_q + b;
        if (fill_q >= size_q) dfr_phase = S_CHECK;
      end
      S_CHECK: begin
        dfr_phase = S_WAIT;
        if (sum_q == b) begin
          if (size_q == 8'd0) push_result(KIND_EMPTY, 5'd0, 8'd0, 1'b0);
          else begin
            for (int i = 0; i < size_q && i < MAX_PAYLOAD; i++)
              push_result(KIND_PAYLOAD, 5'(i), pl_store[i], 1'b0);
          end
          push_result(KIND_ACK, 5'd0, marker_q, 1'b0);
          push_result(KIND_ACK, 5'd0, marker_q, 1'b0);
          push_result(KIND_ACK, 5'd0, hdr_q, 1'b0);
          push_result(KIND_ACK, 5'd0, ACK_NULL_BYTE, 1'b0);
          push_result(KIND_ACK, 5'd0, hdr_q, 1'b1);
        end else begin
          push_result(KIND_ERROR, 5'd0, 8'd0, 1'b1);
        end
      end
      default: dfr_phase = S_WAIT;
    endcase
  endfunction

  // starts and ends at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b);
    @(negedge clk);
  endtask

  task automatic cfg_write(input fpr_reg_t r, input logic [31:0] d);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= d;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (r)
      REG_START_MARKER:  marker_q = d[7:0];
      REG_SETPOINT_PORT: sp_port_q = d[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // wait for the results to drain, then idle before returning
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(input int sz, input bit good_sum, input int extra_markers);
    logic [7:0] hdr;
    logic [7:0] sum;
    logic [7:0] pl;
    repeat (1 + extra_markers) send_byte(marker_q);
    do begin
      hdr = 8'($urandom);
      if ($urandom_range(2) == 0) hdr[7:4] = sp_port_q;
    end while (hdr == marker_q);
    send_byte(hdr);
    send_byte(8'(sz));
    sum = hdr + 8'(sz);
    frame_bytes += 3 + extra_markers;
    if (sz <= MAX_PAYLOAD) begin
      repeat (sz) begin
        pl = 8'($urandom);
        send_byte(pl);
        sum = sum + pl;
      end
      send_byte(good_sum ? sum : sum ^ (8'd1 << $urandom_range(7)));
      frame_bytes += sz + 1;
    end
  endtask

  task automatic random_phase(input int n_bytes);
    int stop_at;
    int pick;
    int sz;
    stop_at = frame_bytes + n_bytes;
    while (frame_bytes < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else if (pick < 14) begin
        send_frame($urandom_range(MAX_PAYLOAD + 1, 255), 1'b1, 0);
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) sz = $urandom_range(0, 6);
        else if (pick < 90) sz = $urandom_range(7, MAX_PAYLOAD - 1);
        else sz = MAX_PAYLOAD;
        send_frame(sz, $urandom_range(99) < 85, ($urandom_range(9) == 0) ? 2 : 0);
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    rx_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: kind %0d value %0h", out_kind, out_value);
        err_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("kind", e.kind, out_kind);
        check_field("port", e.port, out_port);
        check_field("channel", e.channel, out_channel);
        check_field("to_setpoint", e.to_setpoint, out_to_setpoint);
        check_field("length", e.length, out_length);
        check_field("position", e.position, out_position);
        check_field("value", e.value, out_value);
        check_field("last", e.last, out_last);
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = 8'd0;
    out_stall   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = 3'd0;
    cfg_pwdata  = 32'd0;
    marker_q    = START_MARKER_RST;
    sp_port_q   = SETPOINT_PORT_RST;
    dfr_phase   = S_WAIT;
    hdr_q       = 8'd0;
    size_q      = 8'd0;
    fill_q      = 0;
    sum_q       = 8'd0;
    foreach (pl_store[i]) pl_store[i] = 8'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part on the reset settings, no idling
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].rx);
      if (dir_rows[i].typed && (beat_count != dir_rows[i].n_res ||
          (beat_count > 0 && beat_last_kind != dir_rows[i].kind))) begin
        $error("row %0d: expected %0d results ending in kind %0d, predicted %0d",
               i, dir_rows[i].n_res, dir_rows[i].kind, beat_count);
        err_count++;
      end
    end
    drain();

    cfg_write(REG_START_MARKER, 32'h00);
    cfg_write(REG_SETPOINT_PORT, 32'hF);
    random_phase(75);
    drain();

    cfg_write(REG_START_MARKER, 32'hFF);
    cfg_write(REG_SETPOINT_PORT, 32'h0);
    sender_idle_pct = 45;
    random_phase(75);
    drain();

    // long hold-off on the result side while large frames keep coming
    cfg_write(REG_START_MARKER, 32'(START_MARKER_RST));
    cfg_write(REG_SETPOINT_PORT, 32'(SETPOINT_PORT_RST));
    sender_idle_pct = 0;
    rcv_stall_pct = 45;
    hold_left = 300;
    repeat (4) send_frame($urandom_range(15, MAX_PAYLOAD), 1'b1, 0);
    random_phase(60);
    drain();

    cfg_write(REG_START_MARKER, 32'($urandom_range(255)));
    cfg_write(REG_SETPOINT_PORT, 32'($urandom_range(15)));
    sender_idle_pct = 20;
    rcv_stall_pct = 20;
    random_phase(75);
    drain();

    repeat (20) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d expected results never arrived", pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
